>>> design/agls_pkg.sv
// shared constants, codes, state type and a channel helper for the gradient span block
package agls_pkg;

    localparam int FRAC_BITS_DEF = 20;
    localparam int MAX_SPAN_DEF  = 4096;

    localparam int COLOR_W    = 32;
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 4;
    localparam int LEN_REG_W  = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_COLOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN_LENGTH = 2'd2;

    localparam logic [LEN_REG_W-1:0]  SPAN_LENGTH_RST = 13'd256;
    localparam logic [COLOR_W-1:0]    START_COLOR_RST = 32'h0000_0000;
    localparam logic [COLOR_W-1:0]    END_COLOR_RST   = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } agls_state_t;

    // channel 0 is alpha in the top byte, channel 3 is blue in the bottom byte
    function automatic logic [CHAN_W-1:0] chan_of(input logic [COLOR_W-1:0] color,
                                                   input logic [1:0] ch);
        logic [CHAN_W-1:0] v;
        case (ch)
            2'd0:    v = color[31:24];
            2'd1:    v = color[23:16];
            2'd2:    v = color[15:8];
            default: v = color[7:0];
        endcase
        return v;
    endfunction

endpackage

>>> design/agls_req_if.sv
// request channel: one transfer asks for the next pixel
interface agls_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

>>> design/agls_pix_if.sv
// pixel channel: one transfer carries one packed pixel and its end of span flag
interface agls_pix_if
    import agls_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_argb;
    logic               last_in_span;

    modport source (output valid, output pixel_argb, output last_in_span, input ready);
    modport sink   (input valid, input pixel_argb, input last_in_span, output ready);
endinterface

>>> design/agls_cfg_if.sv
// configuration write channel: register index and write data
interface agls_cfg_if
    import agls_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/argb_linear_gradient_span.sv
// linear argb gradient span generator with a shared restoring divider for the steps
//
//  channel  dir  payload                        transfer when
//  cfg      in   index, data                    cfg.valid & cfg.ready (ready always high)
//  req      in   restart                        req.valid & req.ready
//  pix      out  pixel_argb, last_in_span       pix.valid & pix.ready
//
//  a pixel inside a span reaches the output register in the cycle after its request transfer,
//  and requests can follow back to back while the pixel side keeps taking
//  a request that opens a span of more than one pixel waits for the step computation:
//  one shared restoring divider works out the four channel steps a bit a cycle
//  a span of one pixel skips the divider
//  rst_n clears the control state; the first request after reset always opens a span
//  req.ready is low while the divider runs or while an untaken pixel blocks the output register
module argb_linear_gradient_span
    import agls_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int MAX_SPAN  = MAX_SPAN_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    agls_cfg_if.sink     cfg,
    agls_req_if.sink     req,
    agls_pix_if.source   pix
);

    // accumulator: sign, 8 integer bits, FRAC_BITS fraction bits
    localparam int ACC_W = FRAC_BITS + CHAN_W + 1;
    // dividend magnitude: channel difference shifted up by the fraction bits
    localparam int DW    = FRAC_BITS + CHAN_W;
    localparam int LEN_W = $clog2(MAX_SPAN + 1);
    localparam int POS_W = $clog2(MAX_SPAN);
    localparam int CNT_W = $clog2(DW);

    // configuration registers
    logic [COLOR_W-1:0]   start_color_reg;
    logic [COLOR_W-1:0]   end_color_reg;
    logic [LEN_REG_W-1:0] span_length_reg;

    // control state
    agls_state_t          state_reg, state_next;
    logic                 steps_ready_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [1:0]           ch_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 out_valid_reg;

    // datapath state
    logic [ACC_W-1:0]     acc_reg   [NUM_CHAN];
    logic [ACC_W-1:0]     steps_reg [NUM_CHAN];
    logic [DW-1:0]        quo_reg;
    logic [LEN_W-1:0]     rem_reg;
    logic [LEN_W-1:0]     div_reg;
    logic                 neg_reg;
    logic [COLOR_W-1:0]   out_pixel_reg;
    logic                 out_last_reg;

    // control decode
    logic                 req_xfer;
    logic                 begin_span;
    logic                 in_ready;
    logic                 emit;
    logic                 open_span;
    logic                 div_done;
    logic                 last_chan;

    // combinational datapath
    logic [LEN_W-1:0]     n_eff;
    logic                 last_now;
    logic [1:0]           load_ch;
    logic [CHAN_W-1:0]    s_ch;
    logic [CHAN_W-1:0]    e_ch;
    logic                 load_neg;
    logic [DW-1:0]        load_mag;
    logic [LEN_W:0]       trial;
    logic                 ge;
    logic [LEN_W-1:0]     rem_next;
    logic [DW-1:0]        quo_next;
    logic [ACC_W-1:0]     q_ext;
    logic [ACC_W-1:0]     step_val;
    logic [COLOR_W-1:0]   pixel_next;

    // ---------------------------------------------------------------------
    // configuration port, always ready; unknown indexes are dropped
    // ---------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_color_reg <= START_COLOR_RST;
            end_color_reg   <= END_COLOR_RST;
            span_length_reg <= SPAN_LENGTH_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_START_COLOR: start_color_reg <= cfg.data;
                REG_END_COLOR:   end_color_reg   <= cfg.data;
                REG_SPAN_LENGTH: span_length_reg <= cfg.data[LEN_REG_W-1:0];
                default:         ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // span length clamped to 1..MAX_SPAN; the end of span test follows the
    // live register, the divisor is sampled when a span opens
    // ---------------------------------------------------------------------
    always_comb
    begin
        if (span_length_reg == '0)
            n_eff = LEN_W'(1);
        else if (32'(span_length_reg) > 32'(MAX_SPAN))
            n_eff = LEN_W'(MAX_SPAN);
        else
            n_eff = LEN_W'(span_length_reg);
    end

    assign last_now = (LEN_W'(pos_reg) + LEN_W'(1)) >= n_eff;

    // ---------------------------------------------------------------------
    // handshake decode
    // ---------------------------------------------------------------------
    assign req_xfer   = req.valid && req.ready;
    assign begin_span = req.restart || !steps_ready_reg;
    assign div_done   = (cnt_reg == CNT_W'(DW - 1));
    assign last_chan  = (ch_reg == 2'(NUM_CHAN - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer && begin_span)
                begin
                    if (n_eff == LEN_W'(1))
                        state_next = ST_EMIT;
                    else
                        state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done && last_chan)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready  = 1'b0;
        emit      = 1'b0;
        open_span = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = !out_valid_reg || pix.ready;
                emit      = req_xfer && !begin_span;
                open_span = req_xfer && begin_span;
            end
            ST_DIV:
                ;
            ST_EMIT:
                emit = 1'b1;
            default:
                ;
        endcase
    end

    assign req.ready = in_ready;

    // ---------------------------------------------------------------------
    // divider operand load: channel 0 when a span opens, then the next one
    // ---------------------------------------------------------------------
    assign load_ch  = (state_reg == ST_IDLE) ? 2'd0 : ch_reg + 2'd1;
    assign s_ch     = chan_of(start_color_reg, load_ch);
    assign e_ch     = chan_of(end_color_reg, load_ch);
    assign load_neg = s_ch > e_ch;
    assign load_mag = load_neg ? {s_ch - e_ch, {FRAC_BITS{1'b0}}}
                               : {e_ch - s_ch, {FRAC_BITS{1'b0}}};

    // one restoring division bit per cycle; remainder stays below the divisor
    assign trial    = {rem_reg, quo_reg[DW-1]};
    assign ge       = trial >= {1'b0, div_reg};
    assign rem_next = ge ? LEN_W'(trial - {1'b0, div_reg}) : LEN_W'(trial);
    assign quo_next = {quo_reg[DW-2:0], ge};

    // quotient magnitude turned back to a signed step, truncated toward zero
    assign q_ext    = ACC_W'(quo_next);
    assign step_val = neg_reg ? (~q_ext + ACC_W'(1)) : q_ext;

    // pixel from the integer parts of the accumulators
    always_comb
    begin
        pixel_next = '0;
        for (int i = 0; i < NUM_CHAN; i++)
            pixel_next[(NUM_CHAN-1-i)*CHAN_W +: CHAN_W] = acc_reg[i][FRAC_BITS +: CHAN_W];
    end

    // ---------------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            steps_ready_reg <= 1'b0;
            pos_reg         <= '0;
            ch_reg          <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (open_span)
            begin
                steps_ready_reg <= 1'b1;
                pos_reg         <= '0;
                ch_reg          <= '0;
                cnt_reg         <= '0;
            end
            else if (state_reg == ST_DIV)
            begin
                if (div_done)
                begin
                    cnt_reg <= '0;
                    if (!last_chan)
                        ch_reg <= ch_reg + 2'd1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end

            if (emit)
            begin
                if (last_now)
                begin
                    steps_ready_reg <= 1'b0;
                    pos_reg         <= '0;
                end
                else
                begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
            end

            if (emit)
                out_valid_reg <= 1'b1;
            else if (pix.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------------------------------------------------------------
    // datapath registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (open_span)
        begin
            for (int i = 0; i < NUM_CHAN; i++)
            begin
                acc_reg[i]   <= ACC_W'({chan_of(start_color_reg, 2'(i)),
                                        {FRAC_BITS{1'b0}}});
                steps_reg[i] <= '0;
            end
            div_reg <= n_eff - LEN_W'(1);
            rem_reg <= '0;
            quo_reg <= load_mag;
            neg_reg <= load_neg;
        end
        else if (state_reg == ST_DIV)
        begin
            if (div_done)
            begin
                steps_reg[ch_reg] <= step_val;
                rem_reg           <= '0;
                quo_reg           <= load_mag;
                neg_reg           <= load_neg;
            end
            else
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
            end
        end
        else if (emit)
        begin
            for (int i = 0; i < NUM_CHAN; i++)
                acc_reg[i] <= acc_reg[i] + steps_reg[i];
        end

        if (emit)
        begin
            out_pixel_reg <= pixel_next;
            out_last_reg  <= last_now;
        end
    end

    assign pix.valid        = out_valid_reg;
    assign pix.pixel_argb   = out_pixel_reg;
    assign pix.last_in_span = out_last_reg;

    // ---------------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------------

    // the output register is empty for the whole step computation
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> !out_valid_reg)
        else $error("pixel pending while the divider runs");

    // a restart transfer always leaves idle, for the step computation or straight to emit
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_xfer && req.restart) |=> (state_reg == ST_DIV || state_reg == ST_EMIT))
        else $error("restart did not open a span");

    // a new pixel appears only after an emit cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(emit))
        else $error("pixel valid without an emit");

    // the last pixel of a span forces the next request to open a span
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && last_now) |=> (!steps_ready_reg && pos_reg == '0))
        else $error("span end did not clear the step state");

    // the bit counter never runs past the dividend width
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg <= CNT_W'(DW - 1)))
        else $error("divider bit count out of range");

endmodule
